// ----- hdl/char_grid_clipped_rect_fill_macros.svh -----
// Assertion macros shared by the character grid store.
// Included by the top level, which carries the concurrent assertions; needs nothing else.
`ifndef CHAR_GRID_CLIPPED_RECT_FILL_MACROS_SVH
`define CHAR_GRID_CLIPPED_RECT_FILL_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define CGRF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define CGRF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cgrf_pkg.sv -----
// Types and constants of the character grid store.
// Used by the address unit, the cell memory wrapper and the top level.
`timescale 1ns / 1ps

package cgrf_pkg;

  localparam int CHAR_W = 8;   // one character cell
  localparam int POS_W  = 9;   // signed position on the input
  localparam int DIM_W  = 8;   // rectangle width, height and border
  localparam int COL_W  = 7;   // column count register
  localparam int ROW_W  = 6;   // row count register
  localparam int CRD_W  = 10;  // signed position plus rectangle offset
  localparam int OFS_W  = 14;  // row times columns plus column, before trimming
  localparam int PRD_W  = 13;  // row times columns

  typedef logic signed [CRD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RECT  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_INIT_CLR,
    S_IDLE,
    S_CLR,
    S_ADDR,
    S_ACCESS,
    S_RECT,
    S_DRAIN,
    S_RESP
  } state_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } cell_pos_t;

  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
  } geom_t;

endpackage

// ----- hdl/char_grid_clipped_rect_fill.sv -----
// Top level of the character grid store with clipped rectangle painter.
// Depends on cgrf_pkg, cgrf_addr_unit, cgrf_cell_mem and the assertion macros.
//
// Usage. Each word on the in_ channel is one operation, chosen by in_tuser:
// write a cell, read a cell, clear the store or paint a rectangle. Every
// operation returns exactly one word on the out_ channel: the character read
// (zero unless a read landed inside the grid) and an in-grid flag in out_tuser.
// The grid size is set through the cfg_ channel, which is always ready; it is
// to be written only while no operation is in flight.
// Timing. The block handles one operation at a time and drops in_tready from
// acceptance until its result has been loaded into the output register. A
// write or read passes through the address, access and response states
// before its result reaches the output register. A clear sweeps all
// MAX_COLUMNS*MAX_ROWS cells one per cycle (2048 at the defaults). A
// rectangle walks its width*height cells one per cycle through the shared
// address unit; an empty rectangle goes straight to the response state. The
// single memory write port limits both sweeps to this pace.
// Reset. After rst_n the store is zeroed by a clearing pass over all
// MAX_COLUMNS*MAX_ROWS cells, during which in_tready stays low; configuration writes
// are taken meanwhile. Both size registers reset to zero. Stalls. A result waits in
// the output register while out_tready is low; the next operation is accepted as
// soon as the earlier result has left the block sequencer, and a finished operation holds until the register is free.
`timescale 1ns / 1ps
`include "char_grid_clipped_rect_fill_macros.svh"

module char_grid_clipped_rect_fill import cgrf_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[8:0], pos_y[17:9], fill_value[25:18], rect_width[33:26],
  // rect_height[41:34], border_size[49:42], border_value[57:50], zeros above
  input  logic [63:0] in_tdata,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[7:0]
  output logic [7:0]  out_tdata,
  // in_grid[0]
  output logic [0:0]  out_tuser,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELL_COUNT - 1);

  // Sequencer state and the operation being worked on.
  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt;
  logic signed [POS_W-1:0] py_r, py_nxt;
  logic [CHAR_W-1:0]   fv_r, fv_nxt;
  logic [DIM_W-1:0]    w_r, w_nxt;
  logic [DIM_W-1:0]    h_r, h_nxt;
  logic [DIM_W-1:0]    b_r, b_nxt;
  logic [CHAR_W-1:0]   bv_r, bv_nxt;

  // Walk counters for the rectangle and the clearing sweep.
  logic [DIM_W-1:0]    rx_r, rx_nxt;
  logic [DIM_W-1:0]    ry_r, ry_nxt;
  logic [IDX_W-1:0]    clr_idx_r, clr_idx_nxt;

  // Rectangle stage that lines up with the address unit output.
  logic                p_valid_r, p_valid_nxt;
  logic [CHAR_W-1:0]   pix_val_r, pix_val_nxt;

  // Result held until the output register is free.
  logic                res_hit_r, res_hit_nxt;

  // Output register.
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [CHAR_W-1:0]   read_value_r, read_value_nxt;
  logic                in_grid_r, in_grid_nxt;

  // Size registers.
  logic [COL_W-1:0]    cols_r;
  logic [ROW_W-1:0]    rows_r;

  geom_t               geom;
  cell_pos_t           pos;
  logic                hit;
  logic [IDX_W-1:0]    idx;

  logic                mem_wr_en;
  logic [IDX_W-1:0]    mem_wr_addr;
  logic [CHAR_W-1:0]   mem_wr_data;
  logic                mem_rd_en;
  logic [CHAR_W-1:0]   mem_rd_data;

  logic signed [CRD_W-1:0] rx_s, ry_s, w_s, h_s, b_s;
  logic                on_border;
  logic                last_x, last_y;
  logic                out_free;
  op_t                 in_op;

  // Sizes above the build limits are saturated to those limits.
  assign geom.cols = ({2'b00, cols_r} > 9'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : cols_r;
  assign geom.rows = ({3'b000, rows_r} > 9'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : rows_r;

  // The cell being addressed is always origin plus walk offset; the offset is
  // zero for single writes and reads.
  assign pos.x = $signed({px_r[POS_W-1], px_r}) + $signed({2'b00, rx_r});
  assign pos.y = $signed({py_r[POS_W-1], py_r}) + $signed({2'b00, ry_r});

  // Border test in signed arithmetic, so a thick border covers the whole area.
  assign rx_s = $signed({2'b00, rx_r});
  assign ry_s = $signed({2'b00, ry_r});
  assign w_s  = $signed({2'b00, w_r});
  assign h_s  = $signed({2'b00, h_r});
  assign b_s  = $signed({2'b00, b_r});
  assign on_border = (rx_s < b_s) || (rx_s >= w_s - b_s) ||
                     (ry_s < b_s) || (ry_s >= h_s - b_s);

  assign last_x   = (rx_r == w_r - DIM_W'(1));
  assign last_y   = (ry_r == h_r - DIM_W'(1));
  assign out_free = !out_tvalid_r || out_tready;
  assign in_op    = op_t'(in_tuser);

  cgrf_addr_unit #(
    .IDX_W (IDX_W)
  ) u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .pos   (pos),
    .geom  (geom),
    .hit_r (hit),
    .idx_r (idx)
  );

  cgrf_cell_mem #(
    .DEPTH (CELL_COUNT),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (idx),
    .rd_data_r (mem_rd_data)
  );

  // Memory write port: clearing sweep, single write, or rectangle stage.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx;
    mem_wr_data = fv_r;
    if (state_r == S_INIT_CLR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_idx_r;
      mem_wr_data = '0;
    end else if (state_r == S_CLR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_idx_r;
    end else if (state_r == S_ACCESS && op_r == OP_WRITE) begin
      mem_wr_en   = hit;
    end else if (p_valid_r) begin
      mem_wr_en   = hit;
      mem_wr_data = pix_val_r;
    end
  end

  assign mem_rd_en = (state_r == S_ACCESS) && (op_r == OP_READ);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    fv_nxt         = fv_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    b_nxt          = b_r;
    bv_nxt         = bv_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    clr_idx_nxt    = clr_idx_r;
    p_valid_nxt    = 1'b0;
    pix_val_nxt    = on_border ? bv_r : fv_r;
    res_hit_nxt    = res_hit_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    read_value_nxt = read_value_r;
    in_grid_nxt    = in_grid_r;
    in_tready      = 1'b0;

    unique case (state_r)
      S_INIT_CLR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt      = in_op;
          px_nxt      = in_tdata[8:0];
          py_nxt      = in_tdata[17:9];
          fv_nxt      = in_tdata[25:18];
          w_nxt       = in_tdata[33:26];
          h_nxt       = in_tdata[41:34];
          b_nxt       = in_tdata[49:42];
          bv_nxt      = in_tdata[57:50];
          rx_nxt      = '0;
          ry_nxt      = '0;
          clr_idx_nxt = '0;
          res_hit_nxt = 1'b0;
          unique case (in_op)
            OP_WRITE, OP_READ: state_nxt = S_ADDR;
            OP_CLEAR:          state_nxt = S_CLR;
            OP_RECT: begin
              if (in_tdata[33:26] == '0 || in_tdata[41:34] == '0) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_RECT;
              end
            end
            default:           state_nxt = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST_CELL) begin
          state_nxt = S_RESP;
        end
      end
      S_ADDR: begin
        state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        res_hit_nxt = hit;
        state_nxt   = S_RESP;
      end
      S_RECT: begin
        p_valid_nxt = 1'b1;
        if (last_x) begin
          rx_nxt = '0;
          ry_nxt = ry_r + DIM_W'(1);
          if (last_y) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          rx_nxt = rx_r + DIM_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          in_grid_nxt    = res_hit_r;
          read_value_nxt = (op_r == OP_READ && res_hit_r) ? mem_rd_data : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT_CLR;
      clr_idx_r    <= '0;
      p_valid_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      p_valid_r    <= p_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    fv_r         <= fv_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    b_r          <= b_nxt;
    bv_r         <= bv_nxt;
    rx_r         <= rx_nxt;
    ry_r         <= ry_nxt;
    pix_val_r    <= pix_val_nxt;
    res_hit_r    <= res_hit_nxt;
    read_value_r <= read_value_nxt;
    in_grid_r    <= in_grid_nxt;
  end

  // Configuration: always ready, one register per write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= '0;
      rows_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLUMNS: cols_r <= cfg_data;
        CFG_ROWS:    rows_r <= cfg_data[ROW_W-1:0];
        default:     cols_r <= cols_r;
      endcase
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = read_value_r;
  assign out_tuser[0] = in_grid_r;

  // The store is never written while the block is waiting for a new word.
  `CGRF_ASSERT_IMP(a_no_write_when_idle, clk, rst_n, in_tready, !mem_wr_en, "cell write while idle")
  // Accepting a word makes the block busy on the next cycle.
  `CGRF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")
  // A result outside the grid always carries a zero character.
  `CGRF_ASSERT_IMP(a_zero_outside, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0, "nonzero read outside grid")
  // A finished operation with a free output register is presented next cycle.
  `CGRF_ASSERT_NXT(a_result_loaded, clk, rst_n, state_r == S_RESP && out_free, out_tvalid_r, "result not loaded")

endmodule

// ----- hdl/cgrf_addr_unit.sv -----
// Shared address unit: clips a signed cell position against the grid and
// forms the linear cell index. Depends on cgrf_pkg.
`timescale 1ns / 1ps

module cgrf_addr_unit import cgrf_pkg::*; #(
  parameter int IDX_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_pos_t        pos,
  input  geom_t            geom,
  output logic             hit_r,
  output logic [IDX_W-1:0] idx_r
);

  logic             x_ok;
  logic             y_ok;
  logic             hit_nxt;
  logic [PRD_W-1:0] prod;
  logic [OFS_W-1:0] sum;
  logic [IDX_W-1:0] idx_nxt;

  // A zero count makes the upper compare fail, so an empty grid never hits.
  assign x_ok = ($signed(pos.x) >= 0) &&
                ($signed(pos.x) < $signed({3'b000, geom.cols}));
  assign y_ok = ($signed(pos.y) >= 0) &&
                ($signed(pos.y) < $signed({4'b0000, geom.rows}));
  assign hit_nxt = x_ok && y_ok;

  // Only meaningful on a hit, where the row fits six bits and the column seven.
  assign prod    = PRD_W'(pos.y[ROW_W-1:0]) * PRD_W'(geom.cols);
  assign sum     = OFS_W'(prod) + OFS_W'(pos.x[COL_W-1:0]);
  assign idx_nxt = IDX_W'(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

endmodule

// ----- hdl/cgrf_cell_mem.sv -----
// Character cell store: one write port and one registered read port.
// Depends on cgrf_pkg.
`timescale 1ns / 1ps

module cgrf_cell_mem import cgrf_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int IDX_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [CHAR_W-1:0] rd_data_r
);

  logic [CHAR_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cells[rd_addr];
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the character grid store with clipped rectangle painter.
// Needs cgrf_pkg and the char_grid_clipped_rect_fill RTL; it reads no files.
`timescale 1ns / 1ps

module tb_top;
  import cgrf_pkg::*;

  localparam int GRID_MAX_COLS = 64;
  localparam int GRID_MAX_ROWS = 32;
  localparam int CELL_TOTAL    = GRID_MAX_COLS * GRID_MAX_ROWS;
  // The slowest correct run is dominated by the reset sweep, a few dozen full
  // clears and one 255 by 255 rectangle. This limit is many times that figure.
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;

  // One operation as it is offered on the input channel.
  typedef struct packed {
    op_t              kind;
    logic signed [8:0] px;
    logic signed [8:0] py;
    logic [7:0]        fill;
    logic [7:0]        wid;
    logic [7:0]        hgt;
    logic [7:0]        bdr;
    logic [7:0]        bval;
  } grid_op_t;

  // What the block should return for one operation.
  typedef struct packed {
    logic [7:0] rd;
    logic       hit;
  } readback_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index = CFG_COLUMNS;
  logic [6:0]  cfg_data = '0;

  // Operations waiting to be offered, the one on the bus, and what is owed back.
  grid_op_t  op_backlog[$];
  grid_op_t  on_offer = '0;
  logic      in_took = 1'b0;
  readback_t expected_readback[$];

  // Shadow of the store and of its geometry registers.
  logic [7:0] screen_mem [CELL_TOTAL];
  logic [6:0] geo_cols = '0;
  logic [5:0] geo_rows = '0;

  // Traffic shaping, set by the initial block and the hold-off counter, read by the driver processes.
  int  sender_idle_pct = 0;
  int  rx_stall_pct    = 0;
  bit  send_hold       = 1'b0;
  int  hold_reqs       = 0;
  int  holds_done      = 0;
  int  rx_hold_left    = 0;

  int err_count    = 0;
  int cycle_count  = 0;
  int ops_accepted = 0;
  int n_writes     = 0;
  int n_reads      = 0;
  int n_clears     = 0;
  int n_rects      = 0;
  int n_settings   = 0;

  char_grid_clipped_rect_fill #(
    .MAX_COLUMNS(GRID_MAX_COLS),
    .MAX_ROWS   (GRID_MAX_ROWS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every failure goes through here: one line, one count.
  task automatic report_fault(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Maps a signed position to a cell index under the current geometry. A
  // register above its maximum is saturated, and a zero in either register
  // leaves no valid cell at all.
  function automatic bit cell_index(int x, int y, output int idx);
    int c;
    int r;
    c = (int'(geo_cols) > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(geo_cols);
    r = (int'(geo_rows) > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(geo_rows);
    idx = x + y * c;
    return c != 0 && r != 0 && x >= 0 && x < c && y >= 0 && y < r;
  endfunction

  // Applies one operation to the shadow store and returns the word it owes.
  function automatic readback_t apply_grid_op(grid_op_t g);
    readback_t r;
    int idx;
    int x;
    int y;
    int px;
    int py;
    int w;
    int h;
    int b;
    bit on_border;
    r  = '0;
    px = g.px;
    py = g.py;
    case (g.kind)
      OP_WRITE: begin
        n_writes++;
        if (cell_index(px, py, idx)) begin
          screen_mem[idx] = g.fill;
          r.hit = 1'b1;
        end
      end
      OP_READ: begin
        n_reads++;
        if (cell_index(px, py, idx)) begin
          r.rd  = screen_mem[idx];
          r.hit = 1'b1;
        end
      end
      OP_CLEAR: begin
        // The whole store is filled, cells outside the current grid included.
        n_clears++;
        foreach (screen_mem[i]) screen_mem[i] = g.fill;
      end
      default: begin
        // The border test is signed, so a border of half the size or more turns
        // every cell into border, and an empty rectangle paints nothing.
        n_rects++;
        w = g.wid;
        h = g.hgt;
        b = g.bdr;
        for (y = 0; y < h; y++) begin
          for (x = 0; x < w; x++) begin
            on_border = x < b || x >= w - b || y < b || y >= h - b;
            if (cell_index(px + x, py + y, idx))
              screen_mem[idx] = on_border ? g.bval : g.fill;
          end
        end
      end
    endcase
    return r;
  endfunction

  // The store comes out of reset all zero.
  initial begin
    foreach (screen_mem[i]) screen_mem[i] = 8'h00;
  end

  // Input driver: changes only at the falling edge, and holds a word until the
  // rising edge at which it was taken.
  always @(negedge clk) begin : drive_ops
    grid_op_t nxt;
    if (!in_tvalid || in_took) begin
      if (rst_n && !send_hold && op_backlog.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        nxt = op_backlog.pop_front();
        on_offer  <= nxt;
        in_tdata  <= {6'b0, nxt.bval, nxt.bdr, nxt.hgt, nxt.wid, nxt.fill, nxt.py, nxt.px};
        in_tuser  <= nxt.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so that the sender keeps going meanwhile.
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      rx_hold_left <= LONG_HOLD;
      holds_done   <= holds_done + 1;
    end
  end

  // Result acceptor: random back-pressure on top of any long hold.
  always @(negedge clk) begin
    out_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  // Monitor: everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin : watch_ports
    readback_t want;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLUMNS: geo_cols = cfg_data;
          CFG_ROWS:    geo_rows = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_readback.push_back(apply_grid_op(on_offer));
        ops_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_readback.size() == 0) begin
          report_fault($sformatf("result word with no operation outstanding (data %0d)",
                                 out_tdata));
        end else begin
          want = expected_readback.pop_front();
          if (out_tdata !== want.rd)
            report_fault($sformatf("read_value got %0d, want %0d", out_tdata, want.rd));
          if (out_tuser[0] !== want.hit)
            report_fault($sformatf("in_grid got %0b, want %0b", out_tuser[0], want.hit));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out with %0d results still owed.", expected_readback.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Writes one geometry register through the configuration channel.
  task automatic write_reg(cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[6:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(int cols, int rows);
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    n_settings++;
  endtask

  // Returns once nothing is queued, offered or owed, after a further settling wait.
  task automatic wait_drained();
    while (op_backlog.size() != 0 || in_tvalid || expected_readback.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_op(op_t k, int px, int py, int fill, int w = 0, int h = 0,
                         int b = 0, int bv = 0);
    grid_op_t g;
    g.kind = k;
    g.px   = px;
    g.py   = py;
    g.fill = fill;
    g.wid  = w;
    g.hgt  = h;
    g.bdr  = b;
    g.bval = bv;
    op_backlog.push_back(g);
  endtask

  // Mostly positions just around the grid, sometimes anywhere in the 9-bit range.
  function automatic int rand_coord(int span);
    if ($urandom_range(99) < 25) return int'($urandom_range(511)) - 256;
    return int'($urandom_range(span + 1)) - 1;
  endfunction

  // Queues n random operations aimed at a cols by rows geometry. Rectangles are
  // kept small apart from the odd long, thin one, and clears are rare because
  // each sweeps the whole store.
  task automatic queue_random(int n, int cols, int rows);
    int ec;
    int er;
    int pick;
    int shape;
    op_t k;
    ec = (cols > GRID_MAX_COLS) ? GRID_MAX_COLS : cols;
    er = (rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : rows;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 30)      k = OP_WRITE;
      else if (pick < 65) k = OP_READ;
      else if (pick < 68) k = OP_CLEAR;
      else                k = OP_RECT;
      shape = $urandom_range(19);
      if (shape == 0)
        push_op(k, rand_coord(ec), rand_coord(er), $urandom_range(255),
                $urandom_range(255), $urandom_range(3),
                ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(4),
                $urandom_range(255));
      else if (shape == 1)
        push_op(k, rand_coord(ec), rand_coord(er), $urandom_range(255),
                $urandom_range(3), $urandom_range(255),
                ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(4),
                $urandom_range(255));
      else
        push_op(k, rand_coord(ec), rand_coord(er), $urandom_range(255),
                $urandom_range(12), $urandom_range(12),
                ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(4),
                $urandom_range(255));
    end
  endtask

  initial begin : run_test
    int cols;
    int rows;
    int mark;

    // Reset once; the block then runs its own clearing pass before taking words.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on an 8 by 4 grid, no idling on either side.
    set_geometry(8, 4);
    push_op(OP_READ,     0,    0, 8'h00);            // store must start out zeroed
    push_op(OP_WRITE,    0,    0, 8'hFF);
    push_op(OP_WRITE,    7,    3, 8'hA5);            // far corner
    push_op(OP_WRITE,   -1,    0, 8'h11);            // left of the grid, dropped
    push_op(OP_WRITE,    8,    0, 8'h22);            // one past the last column
    push_op(OP_WRITE,    0,    4, 8'h33);            // one past the last row
    push_op(OP_WRITE, -256,  255, 8'h00);            // position extremes
    push_op(OP_WRITE,  255, -256, 8'h7E);
    push_op(OP_READ,     0,    0, 8'h00);
    push_op(OP_READ,     7,    3, 8'h00);
    push_op(OP_READ,     8,    3, 8'h00);
    push_op(OP_READ,  -256, -256, 8'h00);
    push_op(OP_RECT,     0,    0, 8'h44, 0, 5, 1, 8'h99);   // empty: no width
    push_op(OP_RECT,     0,    0, 8'h44, 5, 0, 1, 8'h99);   // empty: no height
    push_op(OP_RECT,     1,    1, 8'h0F, 4, 2, 1, 8'hB0);   // thick border, all border
    push_op(OP_RECT,    -2,   -1, 8'h2E, 6, 4, 1, 8'h2A);   // clipped at top left
    push_op(OP_RECT,     4,    0, 8'h55, 3, 3, 0, 8'hEE);   // no border at all
    push_op(OP_READ,     1,    1, 8'h00);
    push_op(OP_READ,     5,    1, 8'h00);
    // Largest rectangle, mostly off the grid, with a huge border.
    push_op(OP_RECT,  -250, -240, 8'h3C, 255, 255, 128, 8'hC3);
    push_op(OP_READ,     3,    2, 8'h00);
    push_op(OP_CLEAR,    0,    0, 8'h5A);
    push_op(OP_READ,     7,    3, 8'h00);
    push_op(OP_READ,   255,  255, 8'h00);
    push_op(OP_WRITE,    3,    3, 8'h81);
    wait_drained();

    // No valid cell while the column count is zero.
    set_geometry(0, 20);
    queue_random(30, 0, 20);
    wait_drained();

    // Full-size grid with a sender that is mostly idle.
    set_geometry(GRID_MAX_COLS, GRID_MAX_ROWS);
    sender_idle_pct = 88;
    rx_stall_pct    = 0;
    queue_random(100, GRID_MAX_COLS, GRID_MAX_ROWS);
    wait_drained();

    // Both registers at their top value, saturated to the maximum. The receiver
    // stalls heavily and once holds off for a long stretch while words keep
    // coming, so the block backs up onto its input.
    set_geometry(127, 63);
    sender_idle_pct = 0;
    rx_stall_pct    = 88;
    queue_random(80, 127, 63);
    mark = ops_accepted;
    while (ops_accepted < mark + 5) @(posedge clk);
    hold_reqs++;
    wait_drained();

    // Zero rows with light idling on both sides.
    set_geometry(13, 0);
    sender_idle_pct = 15;
    rx_stall_pct    = 15;
    queue_random(30, 13, 0);
    wait_drained();

    // Single-cell grid.
    set_geometry(1, 1);
    queue_random(40, 1, 1);
    wait_drained();

    // Random geometry, some of it oversized. Halfway through the sender stops
    // until every owed word has come back.
    cols = $urandom_range(1, 70);
    rows = $urandom_range(1, 40);
    set_geometry(cols, rows);
    queue_random(90, cols, rows);
    mark = ops_accepted;
    while (ops_accepted < mark + 45) @(posedge clk);
    send_hold = 1'b1;
    while (in_tvalid || expected_readback.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    send_hold = 1'b0;
    wait_drained();

    // Narrow grid: earlier contents are now read under a different layout.
    set_geometry(5, 3);
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    queue_random(80, 5, 3);
    wait_drained();

    repeat (20) @(posedge clk);
    $display("Ran %0d operations: %0d writes, %0d reads, %0d clears, %0d rectangles.",
             ops_accepted, n_writes, n_reads, n_clears, n_rects);
    $display("Used %0d grid settings under four idling patterns, %0d faults seen.",
             n_settings, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
